// ----- design/lsre_pkg.sv -----
// Shared constants and transfer types for the LIFO stack rotate engine.
// Depends on nothing; imported by the engine, its checker and its testbench.
`default_nettype none

package lsre_pkg;

	// DEPTH must stay a power of two: slot arithmetic wraps in PTR_W bits and
	// the store is split into an even and an odd bank by slot parity.
	localparam int DEPTH      = 64;
	localparam int DATA_WIDTH = 32;
	localparam int PTR_W      = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int BANK_AW    = PTR_W - 1;
	localparam int BANK_DEPTH = DEPTH / 2;

	localparam logic [2:0] ACT_PUSH   = 3'd0;
	localparam logic [2:0] ACT_POP    = 3'd1;
	localparam logic [2:0] ACT_DUP    = 3'd2;
	localparam logic [2:0] ACT_SWAP   = 3'd3;
	localparam logic [2:0] ACT_ROT_TB = 3'd4;
	localparam logic [2:0] ACT_ROT_BT = 3'd5;
	localparam logic [2:0] ACT_PEEK   = 3'd6;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_UNDER = 2'd1;
	localparam logic [1:0] ST_OVER  = 2'd2;

	typedef struct packed {
		logic [2:0]            action;
		logic [DATA_WIDTH-1:0] push_value;
	} cmd_t;

	typedef struct packed {
		logic [DATA_WIDTH-1:0] data_word;
		logic [1:0]            status;
		logic [CNT_W-1:0]      entry_count;
		logic                  is_empty;
	} res_t;

endpackage

`default_nettype wire

// ----- design/lifo_stack_rotate_engine_unit.sv -----
// LIFO stack with push, pop, dup, swap, two rotations and peek.
// Depends on lsre_pkg for constants, action and status codes, and transfer types.
// Pipeline: an accepted command is registered into the second stage along with
// its bank reads, then into the result register, which raises done.
// Throughput: one command per cycle; busy never rises, since every command
// reads at most two neighboring slots and writes at most two, one per bank.
// Reset clears the entry count, the bottom pointer and both strobes; stored
// words stay undefined until pushed, and no unwritten word is ever read out.
`default_nettype none

module lifo_stack_rotate_engine_unit (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  lsre_pkg::cmd_t     cmd,
	output logic               busy,
	output logic               done,
	output lsre_pkg::res_t     result
);
	import lsre_pkg::*;

	// Source of the primary store write.
	typedef enum logic [1:0] {
		WS_VALUE,   // push operand
		WS_TOP,     // word read at the read slot
		WS_NEXT     // word read one slot below the read slot
	} wsrc_t;

	// Everything the second stage needs about one command.
	typedef struct packed {
		logic                  we;       // primary write
		logic                  sw2;      // swap: second write one slot below
		wsrc_t                 wsrc;
		logic [PTR_W-1:0]      wslot;
		logic                  rpar;     // bank holding the read slot
		logic                  dat_en;   // command returns the read word
		logic [DATA_WIDTH-1:0] val;
		logic [1:0]            status;
		logic [CNT_W-1:0]      cnt;
	} ctl_t;

	logic                  accept;
	logic [CNT_W-1:0]      occ_q, occ_d;
	logic [PTR_W-1:0]      bot_q, bot_d;
	logic [PTR_W-1:0]      top_slot, nxt_slot, rslot, rslot_lo;
	logic                  is_empty_now, is_full_now, two_plus;
	ctl_t                  ctl_d, ctl_s1;
	logic                  vld_s1;

	logic [DATA_WIDTH-1:0] bank_mem [2][BANK_DEPTH];
	logic [DATA_WIDTH-1:0] rd_s1 [2];
	logic [1:0]            bwe;
	logic [BANK_AW-1:0]    bwi [2];
	logic [BANK_AW-1:0]    bri [2];
	logic [DATA_WIDTH-1:0] bwd [2];

	logic [DATA_WIDTH-1:0] word_a, word_b, wdat;
	logic [PTR_W-1:0]      slot2;

	logic                  done_q;
	res_t                  res_q;

	// No command needs more than one pass through the pipeline, so the command side never stalls.
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// ---------------------------------------------------------------------
	// Accept stage: decode against the live count and bottom pointer.
	// Entry i from the bottom sits in slot (bot_q + i) mod DEPTH.
	// ---------------------------------------------------------------------
	assign is_empty_now = (occ_q == '0);
	assign is_full_now  = (occ_q == CNT_W'(DEPTH));
	assign two_plus     = (occ_q >= CNT_W'(2));
	assign nxt_slot     = bot_q + occ_q[PTR_W-1:0];
	assign top_slot     = nxt_slot - PTR_W'(1);

	always_comb begin
		occ_d        = occ_q;
		bot_d        = bot_q;
		rslot        = top_slot;
		ctl_d.we     = 1'b0;
		ctl_d.sw2    = 1'b0;
		ctl_d.wsrc   = WS_TOP;
		ctl_d.wslot  = nxt_slot;
		ctl_d.dat_en = 1'b0;
		ctl_d.status = ST_OK;
		case (cmd.action)
			ACT_PUSH: begin
				if (is_full_now) begin
					ctl_d.status = ST_OVER;
				end else begin
					ctl_d.we   = 1'b1;
					ctl_d.wsrc = WS_VALUE;
					occ_d      = occ_q + CNT_W'(1);
				end
			end
			ACT_POP: begin
				if (is_empty_now) begin
					ctl_d.status = ST_UNDER;
				end else begin
					ctl_d.dat_en = 1'b1;
					occ_d        = occ_q - CNT_W'(1);
				end
			end
			ACT_DUP: begin
				if (is_empty_now) begin
					ctl_d.status = ST_UNDER;
				end else if (is_full_now) begin
					ctl_d.status = ST_OVER;
				end else begin
					ctl_d.we     = 1'b1;
					ctl_d.dat_en = 1'b1;
					occ_d        = occ_q + CNT_W'(1);
				end
			end
			ACT_SWAP: begin
				// Top gets the word below it, the slot below gets the old top.
				if (two_plus) begin
					ctl_d.we    = 1'b1;
					ctl_d.sw2   = 1'b1;
					ctl_d.wsrc  = WS_NEXT;
					ctl_d.wslot = top_slot;
				end
			end
			ACT_ROT_TB: begin
				// Step the bottom down and drop the top word there.
				if (two_plus) begin
					ctl_d.we    = 1'b1;
					ctl_d.wslot = bot_q - PTR_W'(1);
					bot_d       = bot_q - PTR_W'(1);
				end
			end
			ACT_ROT_BT: begin
				// Copy the bottom word above the top, then step the bottom up.
				if (two_plus) begin
					ctl_d.we = 1'b1;
					rslot    = bot_q;
					bot_d    = bot_q + PTR_W'(1);
				end
			end
			ACT_PEEK: begin
				if (is_empty_now) begin
					ctl_d.status = ST_UNDER;
				end else begin
					ctl_d.dat_en = 1'b1;
				end
			end
			default: begin
			end
		endcase
		ctl_d.rpar = rslot[0];
		ctl_d.val  = cmd.push_value;
		ctl_d.cnt  = occ_d;
	end

	// Each bank reads the one of {rslot, rslot-1} with its parity.
	assign rslot_lo = rslot - PTR_W'(1);
	always_comb begin
		for (int k = 0; k < 2; k++) begin
			bri[k] = (rslot[0] == 1'(k)) ? rslot[PTR_W-1:1] : rslot_lo[PTR_W-1:1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q  <= '0;
			bot_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			if (accept) begin
				occ_q <= occ_d;
				bot_q <= bot_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1 <= ctl_d;
		end
	end

	// ---------------------------------------------------------------------
	// Entry store: even and odd slot banks, one write and one registered read
	// each. A read that meets this cycle's write to the same entry takes the
	// new word, so back-to-back commands see each other's updates.
	// ---------------------------------------------------------------------
	always_ff @(posedge clk) begin
		for (int k = 0; k < 2; k++) begin
			if (bwe[k]) begin
				bank_mem[k][bwi[k]] <= bwd[k];
			end
			rd_s1[k] <= (bwe[k] && (bwi[k] == bri[k])) ? bwd[k] : bank_mem[k][bri[k]];
		end
	end

	// ---------------------------------------------------------------------
	// Second stage: pick the read words, steer the writes to their banks.
	// ---------------------------------------------------------------------
	assign word_a = rd_s1[ctl_s1.rpar];
	assign word_b = rd_s1[!ctl_s1.rpar];
	assign slot2  = ctl_s1.wslot - PTR_W'(1);

	always_comb begin
		case (ctl_s1.wsrc)
			WS_VALUE: wdat = ctl_s1.val;
			WS_NEXT:  wdat = word_b;
			default:  wdat = word_a;
		endcase
	end

	always_comb begin
		for (int k = 0; k < 2; k++) begin
			if (vld_s1 && ctl_s1.we && (ctl_s1.wslot[0] == 1'(k))) begin
				bwe[k] = 1'b1;
				bwi[k] = ctl_s1.wslot[PTR_W-1:1];
				bwd[k] = wdat;
			end else begin
				// Swap's second write: the old top into the slot below.
				bwe[k] = vld_s1 && ctl_s1.we && ctl_s1.sw2 && (slot2[0] == 1'(k));
				bwi[k] = slot2[PTR_W-1:1];
				bwd[k] = word_a;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Result register: one strobed transfer per command.
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			res_q.data_word   <= ctl_s1.dat_en ? word_a : '0;
			res_q.status      <= ctl_s1.status;
			res_q.entry_count <= ctl_s1.cnt;
			res_q.is_empty    <= (ctl_s1.cnt == '0);
		end
	end

	assign done   = done_q;
	assign result = res_q;

	// ---------------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------------
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##2 done)
		else $error("result transfer missing two cycles after accept");

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CNT_W'(DEPTH))
		else $error("entry count above depth");

	a_swap_banks: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && ctl_s1.sw2) |-> (bwe == 2'b11))
		else $error("swap writes did not land in both banks");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.status != ST_OK)) |-> (result.data_word == '0))
		else $error("error result carries a data word");

	a_over_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.status == ST_OVER)) |-> (result.entry_count == CNT_W'(DEPTH)))
		else $error("overflow reported on a stack that is not full");

endmodule

`default_nettype wire

// ----- tb/lsre_stack_checker.sv -----
// Checker for lifo_stack_rotate_engine_unit: watches the command and result
// transfers, keeps a shadow stack and compares every result field by field.
// Depends on lsre_pkg for the action and status codes and the transfer types.

module lsre_stack_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           busy,
	input  lsre_pkg::cmd_t cmd,
	input  logic           done,
	input  lsre_pkg::res_t result,
	output int             errors,
	output int             pending
);
	import lsre_pkg::*;

	logic [DATA_WIDTH-1:0] shadow_words [DEPTH];
	logic [CNT_W-1:0]      depth_cnt;
	logic [PTR_W-1:0]      bottom_ptr;
	res_t                  expected_results [$];

	initial errors = 0;

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		$display("[%0t] stack mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
		errors++;
	endtask

	// Apply one command to the shadow stack and return the result it owes.
	function automatic res_t apply_stack_op(input cmd_t c);
		res_t                  r;
		logic [PTR_W-1:0]      top_slot;
		logic [PTR_W-1:0]      sec_slot;
		logic [PTR_W-1:0]      next_slot;
		logic [DATA_WIDTH-1:0] w;
		r         = '0;
		r.status  = ST_OK;
		top_slot  = bottom_ptr + PTR_W'(depth_cnt) - PTR_W'(1);
		sec_slot  = bottom_ptr + PTR_W'(depth_cnt) - PTR_W'(2);
		next_slot = bottom_ptr + PTR_W'(depth_cnt);
		case (c.action)
			ACT_PUSH: begin
				if (depth_cnt == DEPTH) begin
					r.status = ST_OVER;
				end else begin
					shadow_words[next_slot] = c.push_value;
					depth_cnt = depth_cnt + CNT_W'(1);
				end
			end
			ACT_POP: begin
				if (depth_cnt == 0) begin
					r.status = ST_UNDER;
				end else begin
					r.data_word = shadow_words[top_slot];
					depth_cnt = depth_cnt - CNT_W'(1);
				end
			end
			ACT_DUP: begin
				if (depth_cnt == 0) begin
					r.status = ST_UNDER;
				end else if (depth_cnt == DEPTH) begin
					r.status = ST_OVER;
				end else begin
					r.data_word = shadow_words[top_slot];
					shadow_words[next_slot] = r.data_word;
					depth_cnt = depth_cnt + CNT_W'(1);
				end
			end
			ACT_SWAP: begin
				if (depth_cnt >= 2) begin
					w = shadow_words[top_slot];
					shadow_words[top_slot] = shadow_words[sec_slot];
					shadow_words[sec_slot] = w;
				end
			end
			ACT_ROT_TB: begin
				if (depth_cnt >= 2) begin
					w = shadow_words[top_slot];
					bottom_ptr = bottom_ptr - PTR_W'(1);
					shadow_words[bottom_ptr] = w;
				end
			end
			ACT_ROT_BT: begin
				if (depth_cnt >= 2) begin
					w = shadow_words[bottom_ptr];
					shadow_words[next_slot] = w;
					bottom_ptr = bottom_ptr + PTR_W'(1);
				end
			end
			ACT_PEEK: begin
				if (depth_cnt == 0)
					r.status = ST_UNDER;
				else
					r.data_word = shadow_words[top_slot];
			end
			default: ;
		endcase
		r.entry_count = depth_cnt;
		r.is_empty    = (depth_cnt == 0);
		return r;
	endfunction

	// Predict before comparing so the queue order holds for any latency.
	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			depth_cnt  = '0;
			bottom_ptr = '0;
			expected_results.delete();
			pending = 0;
		end else begin
			if (start && !busy)
				expected_results.push_back(apply_stack_op(cmd));
			if (done) begin
				if (expected_results.size() == 0) begin
					report_mismatch("unrequested result", 64'(result), 64'd0);
				end else begin
					want = expected_results.pop_front();
					if (result.data_word !== want.data_word)
						report_mismatch("data_word", 64'(result.data_word), 64'(want.data_word));
					if (result.status !== want.status)
						report_mismatch("status", 64'(result.status), 64'(want.status));
					if (result.entry_count !== want.entry_count)
						report_mismatch("entry_count", 64'(result.entry_count),
							64'(want.entry_count));
					if (result.is_empty !== want.is_empty)
						report_mismatch("is_empty", 64'(result.is_empty), 64'(want.is_empty));
				end
			end
			pending = expected_results.size();
		end
	end

endmodule

// ----- tb/lifo_stack_rotate_engine_unit_tb.sv -----
// Top of the stack engine testbench: clock, reset, command stimulus, verdict.
// Depends on lsre_pkg, lifo_stack_rotate_engine_unit and lsre_stack_checker.

module lifo_stack_rotate_engine_unit_tb;
	import lsre_pkg::*;

	// Action 7 has no package name; the block must treat it as a no-op.
	localparam logic [2:0] ACT_NONE = 3'd7;
	localparam int RANDOM_ITEMS = 1250;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic start  = 1'b0;
	cmd_t cmd    = '0;
	logic busy;
	logic done;
	res_t result;
	int   fail_count;
	int   pending;
	int   idle_pct   = 0;
	int   items_sent = 0;

	always #5 clk = ~clk;

	lifo_stack_rotate_engine_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	lsre_stack_checker checker_i (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.cmd     (cmd),
		.done    (done),
		.result  (result),
		.errors  (fail_count),
		.pending (pending)
	);

	// Drive one command and hold it until the transfer completes. Each idle
	// cycle lowers start once per time step; start is raised only on the
	// step after, so back-to-back commands keep start high without a glitch.
	task automatic issue_cmd(input logic [2:0] act, input logic [DATA_WIDTH-1:0] val);
		cmd_t c;
		c.action     = act;
		c.push_value = val;
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		cmd   <= c;
		// Accepted at the first edge where busy was low just before it.
		do
			@(posedge clk);
		while (busy);
		items_sent++;
	endtask

	// Mostly random words, with the all-zero and all-one extremes mixed in.
	function automatic logic [DATA_WIDTH-1:0] pick_word();
		if ($urandom_range(0, 7) == 0)
			return $urandom_range(0, 1) ? '1 : '0;
		return $urandom;
	endfunction

	// Weight pushes above pops so the stack wanders up from empty.
	function automatic logic [2:0] pick_action();
		int r;
		r = $urandom_range(0, 99);
		if (r < 34) return ACT_PUSH;
		if (r < 52) return ACT_POP;
		if (r < 62) return ACT_DUP;
		if (r < 72) return ACT_SWAP;
		if (r < 80) return ACT_ROT_TB;
		if (r < 88) return ACT_ROT_BT;
		if (r < 97) return ACT_PEEK;
		return ACT_NONE;
	endfunction

	// Fill past full, churn while full, then drain past empty, so that
	// overflow and the full-ring rotations are reached.
	task automatic fill_churn_drain();
		logic [2:0] full_ops [6];
		full_ops = '{ACT_PUSH, ACT_DUP, ACT_ROT_TB, ACT_ROT_BT, ACT_SWAP, ACT_PEEK};
		repeat (DEPTH + 2)
			issue_cmd(ACT_PUSH, pick_word());
		repeat (12)
			issue_cmd(full_ops[$urandom_range(0, 5)], pick_word());
		repeat (DEPTH + 3)
			issue_cmd(ACT_POP, pick_word());
	endtask

	// Pick the sender gap rate from how far the random part has gone.
	task automatic set_idle_phase(input int done_items);
		if (done_items < RANDOM_ITEMS / 4)
			idle_pct = 0;
		else if (done_items < RANDOM_ITEMS / 2)
			idle_pct = 88;
		else if (done_items < 3 * RANDOM_ITEMS / 4)
			idle_pct = 22;
		else
			idle_pct = 0;
	endtask

	initial begin
		int base;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: every action on an empty stack, then one, two and more entries.
		issue_cmd(ACT_POP,    32'h1234_5678);
		issue_cmd(ACT_PEEK,   '0);
		issue_cmd(ACT_DUP,    '1);
		issue_cmd(ACT_SWAP,   '0);
		issue_cmd(ACT_ROT_TB, '0);
		issue_cmd(ACT_ROT_BT, '0);
		issue_cmd(ACT_NONE,   '1);
		issue_cmd(ACT_PUSH,   '1);
		issue_cmd(ACT_SWAP,   '0);
		issue_cmd(ACT_ROT_TB, '0);
		issue_cmd(ACT_ROT_BT, '0);
		issue_cmd(ACT_PEEK,   '0);
		issue_cmd(ACT_PUSH,   '0);
		// Swap with exactly two entries must also fix up the bottom word.
		issue_cmd(ACT_SWAP,   '0);
		issue_cmd(ACT_PEEK,   '0);
		issue_cmd(ACT_ROT_TB, '0);
		issue_cmd(ACT_ROT_BT, '0);
		issue_cmd(ACT_PUSH,   32'hA5A5_A5A5);
		issue_cmd(ACT_DUP,    '0);
		issue_cmd(ACT_PUSH,   32'h5A5A_5A5A);
		issue_cmd(ACT_ROT_BT, '0);
		issue_cmd(ACT_POP,    '0);
		issue_cmd(ACT_NONE,   '0);
		issue_cmd(ACT_POP,    '0);

		// Random: start with one full sweep, then mostly short random runs.
		base = items_sent;
		fill_churn_drain();
		while (items_sent - base < RANDOM_ITEMS) begin
			set_idle_phase(items_sent - base);
			if ($urandom_range(0, 9) == 0)
				fill_churn_drain();
			else
				repeat (20)
					issue_cmd(pick_action(), pick_word());
		end
		start <= 1'b0;

		// Drain outstanding results, then keep watching for stray results before the verdict.
		wait (pending == 0);
		repeat (8) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("lifo_stack_rotate_engine_unit_tb: clean");
		else
			$display("lifo_stack_rotate_engine_unit_tb: errors");
		$finish;
	end

	// Hang guard: far beyond the time a normal run takes.
	initial begin
		#2000000;
		$display("lifo_stack_rotate_engine_unit_tb: errors");
		$finish;
	end

endmodule

// ----- filelist.f -----
design/lsre_pkg.sv
design/lifo_stack_rotate_engine_unit.sv
tb/lsre_stack_checker.sv
tb/lifo_stack_rotate_engine_unit_tb.sv
